[rtl/core/lslf_pkg.sv]
`default_nettype none
package lslf_pkg;

  // internal widths, sized for the largest supported point count (2^20)
  localparam int CW  = 21;        // point count
  localparam int SW  = 16 + CW;   // x and y sums, signed
  localparam int PW  = 31 + CW;   // product sums, signed
  localparam int MW  = 2 * SW;    // multiplier operand magnitude
  localparam int TW  = 2 * MW + 2; // signed working word of the back end
  localparam int NW  = 160;       // divider numerator
  localparam int DNW = TW;        // divider denominator
  localparam int MAX_POINTS_DEFAULT = 65536;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FLAT = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [16:0] R2_ONE = 17'd65536;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [16:0]        r2_fit;
    logic [1:0]         fit_status;
  } fit_t;

  typedef struct packed {
    logic [CW-1:0]        n;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [PW-1:0] sxy;
    logic signed [PW-1:0] sxx;
    logic signed [PW-1:0] syy;
    logic                 ovf;
  } sums_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } queue_status_t;

  // rounded magnitude quotient to saturated signed 32 bits
  function automatic logic [31:0] sat32(input logic [NW-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > NW'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[31:0];
    end else begin
      r = (q > NW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/least_squares_line_fit.sv]
`default_nettype none
// channel   direction  handshake                       payload
// point     in         start high, busy low            x_value, y_value, last_point
// result    out        result_valid, one cycle         slope, intercept, r2_fit, fit_status
// config    in         apb write, psel&penable&pwrite  spread_threshold when paddr[2] is 0
//
// points are taken one per cycle while busy is low; a two-stage accumulator adds each point.
// a finished set enters a two-entry queue; the back end then runs up to
// eleven products through the shared multiplier and up to three quotients
// through the shared divider.
// busy rises only while the queue cannot take another finished set.
// synchronous active-high reset clears sums, queue and sequencer; the
// threshold returns to 1. the receiver cannot stall: results are strobed.
module least_squares_line_fit #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire lslf_pkg::point_t point,
  output logic                  result_valid,
  output lslf_pkg::fit_t        result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import lslf_pkg::*;

  logic          accept;
  logic          pend_last;
  logic          push;
  logic          pop;
  sums_t         snap;
  sums_t         head;
  queue_status_t qstat;
  logic [31:0]   spread_threshold;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_threshold <= 32'd1;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      spread_threshold <= pwdata;
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? spread_threshold : 32'd0;

  // request handshake
  assign busy   = qstat.full || ((qstat.count == 2'd1) && pend_last);
  assign accept = start && !busy;

  lslf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .point     (point),
    .pend_last (pend_last),
    .push      (push),
    .snap      (snap)
  );

  lslf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (snap),
    .pop    (pop),
    .head   (head),
    .status (qstat)
  );

  lslf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .threshold    (spread_threshold),
    .head         (head),
    .queue_empty  (qstat.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // results are spaced by the multi-cycle back end
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("back-to-back results");

  // the queue never takes a set while full
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("queue overrun");

  // r squared stays within one
  a_r2_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.r2_fit <= R2_ONE)) else $error("r squared above one");

  // failed fits give zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.fit_status != ST_OK)) |->
      ((result.slope == 0) && (result.intercept == 0) && (result.r2_fit == 0)))
    else $error("nonzero fields on failed fit");

endmodule
`default_nettype wire

[rtl/core/lslf_front.sv]
`default_nettype none
module lslf_front #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire lslf_pkg::point_t point,
  output logic                 pend_last,
  output logic                 push,
  output lslf_pkg::sums_t      snap
);
  import lslf_pkg::*;

  logic                 s1_valid;
  logic                 s1_last;
  logic signed [15:0]   s1_x;
  logic signed [15:0]   s1_y;
  logic signed [31:0]   s1_xy;
  logic signed [31:0]   s1_xx;
  logic signed [31:0]   s1_yy;

  sums_t acc;
  sums_t acc_next;

  // stage one: products of the point
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept & point.last_point;
    end
    s1_x  <= point.x_value;
    s1_y  <= point.y_value;
    s1_xy <= point.x_value * point.y_value;
    s1_xx <= point.x_value * point.x_value;
    s1_yy <= point.y_value * point.y_value;
  end

  // stage two: running sums
  always_comb begin
    acc_next = acc;
    if (s1_valid) begin
      if (acc.n < CW'(MAX_POINTS)) begin
        acc_next.n   = acc.n + CW'(1);
        acc_next.sx  = acc.sx + SW'(s1_x);
        acc_next.sy  = acc.sy + SW'(s1_y);
        acc_next.sxy = acc.sxy + PW'(s1_xy);
        acc_next.sxx = acc.sxx + PW'(s1_xx);
        acc_next.syy = acc.syy + PW'(s1_yy);
      end else begin
        acc_next.ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_valid && s1_last)) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign push      = s1_valid & s1_last;
  assign snap      = acc_next;
  assign pend_last = s1_valid & s1_last;

endmodule
`default_nettype wire

[rtl/core/lslf_queue.sv]
`default_nettype none
module lslf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lslf_pkg::sums_t      wdata,
  input  wire logic                 pop,
  output lslf_pkg::sums_t           head,
  output lslf_pkg::queue_status_t   status
);
  import lslf_pkg::*;

  sums_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // two-entry fifo of finished sets
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) entry[wr_ptr] <= wdata;
  end

  assign head         = entry[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign status.count = count;

endmodule
`default_nettype wire

[rtl/core/lslf_mul.sv]
`default_nettype none
module lslf_mul (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [lslf_pkg::TW-1:0] a,
  input  wire logic signed [lslf_pkg::TW-1:0] b,
  output logic                                done,
  output logic signed [lslf_pkg::TW-1:0]      p
);
  import lslf_pkg::*;

  localparam int CNTW = $clog2(MW + 1);

  logic [TW-1:0]   a_abs;
  logic [TW-1:0]   b_abs;
  logic [2*MW-1:0] prod;
  logic [2*MW-1:0] mcand;
  logic [MW-1:0]   mplier;
  logic [CNTW-1:0] cnt;
  logic            neg;
  logic            run;

  assign a_abs = a[TW-1] ? (~a + TW'(1)) : a;
  assign b_abs = b[TW-1] ? (~b + TW'(1)) : b;

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && (cnt == CNTW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(MW);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      prod   <= '0;
      mcand  <= {{MW{1'b0}}, a_abs[MW-1:0]};
      mplier <= b_abs[MW-1:0];
      neg    <= a[TW-1] ^ b[TW-1];
    end else if (run) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= {mcand[2*MW-2:0], 1'b0};
      mplier <= {1'b0, mplier[MW-1:1]};
    end
  end

  assign p = neg ? (~{2'b00, prod} + TW'(1)) : {2'b00, prod};

endmodule
`default_nettype wire

[rtl/core/lslf_div.sv]
`default_nettype none
module lslf_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lslf_pkg::NW-1:0]   num,
  input  wire logic [lslf_pkg::DNW-1:0]  den,
  output logic                           done,
  output logic [lslf_pkg::NW-1:0]        q
);
  import lslf_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]    t;
  logic [DNW:0]     d;
  logic [DNW+1:0]   rem;
  logic [DNW+1:0]   trial;
  logic             fits;
  logic [CNTW-1:0]  cnt;
  logic             run;

  assign trial = {rem[DNW:0], t[NW-1]};
  assign fits  = (trial >= {1'b0, d});

  // restoring division of (2*num + den) by 2*den, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && (cnt == CNTW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      t   <= {num[NW-2:0], 1'b0} + NW'(den);
      d   <= {den, 1'b0};
      rem <= '0;
      q   <= '0;
    end else if (run) begin
      rem <= fits ? (trial - {1'b0, d}) : trial;
      t   <= {t[NW-2:0], 1'b0};
      q   <= {q[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[rtl/core/lslf_back.sv]
`default_nettype none
module lslf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          threshold,
  input  wire lslf_pkg::sums_t      head,
  input  wire logic                 queue_empty,
  output logic                      pop,
  output logic                      result_valid,
  output lslf_pkg::fit_t            result
);
  import lslf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MULGO  = 3'd1;
  localparam logic [2:0] S_MULW   = 3'd2;
  localparam logic [2:0] S_DIVGO  = 3'd3;
  localparam logic [2:0] S_DIVW   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic [3:0] OP_NXX  = 4'd0;
  localparam logic [3:0] OP_SXX  = 4'd1;
  localparam logic [3:0] OP_NYY  = 4'd2;
  localparam logic [3:0] OP_SYY  = 4'd3;
  localparam logic [3:0] OP_NXY  = 4'd4;
  localparam logic [3:0] OP_SXY  = 4'd5;
  localparam logic [3:0] OP_YDXX = 4'd6;
  localparam logic [3:0] OP_XDXY = 4'd7;
  localparam logic [3:0] OP_NDXX = 4'd8;
  localparam logic [3:0] OP_DXY2 = 4'd9;
  localparam logic [3:0] OP_DXDY = 4'd10;

  localparam logic [1:0] DV_SLOPE = 2'd0;
  localparam logic [1:0] DV_ICPT  = 2'd1;
  localparam logic [1:0] DV_R2    = 2'd2;

  logic [2:0] state;
  logic [3:0] op;
  logic [1:0] dv;

  logic signed [TW-1:0] n, sx, sy, sxy, sxx, syy;
  logic signed [TW-1:0] dxx, dyy, dxy, tmp, inum, iden, rden;
  fit_t                 res;

  logic signed [TW-1:0] mul_a, mul_b, mul_p;
  logic                 mul_start, mul_done;
  logic [NW-1:0]        div_num, div_q;
  logic [DNW-1:0]       div_den;
  logic                 div_start, div_done;
  logic [TW-1:0]        dxy_abs, inum_abs;
  logic [TW+15:0]       dxy_sh;
  logic [TW+15:0]       tmp_sh;
  logic [TW+7:0]        inum_sh;
  logic                 dxx_flat, dyy_flat;

  assign dxx_flat = (dxx <= 0) || (dxx < $signed({{(TW-32){1'b0}}, threshold}));
  assign dyy_flat = (dyy <= 0) || (dyy < $signed({{(TW-32){1'b0}}, threshold}));

  // operand select for the shared multiplier
  always_comb begin
    case (op)
      OP_NXX:  begin mul_a = n;   mul_b = sxx; end
      OP_SXX:  begin mul_a = sx;  mul_b = sx;  end
      OP_NYY:  begin mul_a = n;   mul_b = syy; end
      OP_SYY:  begin mul_a = sy;  mul_b = sy;  end
      OP_NXY:  begin mul_a = n;   mul_b = sxy; end
      OP_SXY:  begin mul_a = sx;  mul_b = sy;  end
      OP_YDXX: begin mul_a = sy;  mul_b = dxx; end
      OP_XDXY: begin mul_a = sx;  mul_b = dxy; end
      OP_NDXX: begin mul_a = n;   mul_b = dxx; end
      OP_DXY2: begin mul_a = dxy; mul_b = dxy; end
      OP_DXDY: begin mul_a = dxx; mul_b = dyy; end
      default: begin mul_a = '0;  mul_b = '0;  end
    endcase
  end

  // operand select for the shared divider
  assign dxy_abs  = dxy[TW-1] ? (~dxy + TW'(1)) : dxy;
  assign inum_abs = inum[TW-1] ? (~inum + TW'(1)) : inum;
  assign dxy_sh   = {dxy_abs, 16'd0};
  assign tmp_sh   = {tmp, 16'd0};
  assign inum_sh  = {inum_abs, 8'd0};

  always_comb begin
    case (dv)
      DV_SLOPE: begin div_num = dxy_sh[NW-1:0];  div_den = dxx;  end
      DV_ICPT:  begin div_num = inum_sh[NW-1:0]; div_den = iden; end
      DV_R2:    begin div_num = tmp_sh[NW-1:0];  div_den = rden; end
      default:  begin div_num = '0;              div_den = '0;   end
    endcase
  end

  assign mul_start = (state == S_MULGO);
  assign div_start = (state == S_DIVGO);
  assign pop       = (state == S_IDLE) && !queue_empty;

  lslf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  lslf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // sequencer over the fit computation
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_NXX;
      dv           <= DV_SLOPE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            op  <= OP_NXX;
            dv  <= DV_SLOPE;
            if (head.ovf) begin
              res   <= '{32'sd0, 32'sd0, 17'd0, ST_OVF};
              state <= S_OUT;
            end else if (head.n < CW'(2)) begin
              res   <= '{32'sd0, 32'sd0, 17'd0, ST_FEW};
              state <= S_OUT;
            end else begin
              res   <= '0;
              state <= S_MULGO;
            end
          end
        end
        S_MULGO: begin
          state <= S_MULW;
        end
        S_MULW: begin
          if (mul_done) begin
            case (op)
              OP_SXX:  dxx  <= tmp - mul_p;
              OP_SYY:  dyy  <= tmp - mul_p;
              OP_SXY:  dxy  <= tmp - mul_p;
              OP_XDXY: inum <= tmp - mul_p;
              OP_NDXX: iden <= mul_p;
              OP_DXDY: rden <= mul_p;
              default: tmp  <= mul_p;
            endcase
            op    <= op + 4'd1;
            state <= (op == OP_DXDY) ? S_DIVGO : S_MULGO;
          end else if (op == OP_YDXX && dxx_flat) begin
            res.fit_status <= ST_FLAT;
            state          <= S_OUT;
          end
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            case (dv)
              DV_SLOPE: begin
                res.slope <= sat32(div_q, dxy[TW-1]);
                dv        <= DV_ICPT;
                state     <= S_DIVGO;
              end
              DV_ICPT: begin
                if (dyy_flat) begin
                  res   <= '{res.slope, sat32(div_q, inum[TW-1]), R2_ONE, res.fit_status};
                  state <= S_OUT;
                end else begin
                  res.intercept <= sat32(div_q, inum[TW-1]);
                  dv            <= DV_R2;
                  state         <= S_DIVGO;
                end
              end
              default: begin
                res.r2_fit <= (div_q > NW'(R2_ONE)) ? R2_ONE : div_q[16:0];
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          result <= res;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (pop) begin
      n   <= {{(TW-CW){1'b0}}, head.n};
      sx  <= {{(TW-SW){head.sx[SW-1]}}, head.sx};
      sy  <= {{(TW-SW){head.sy[SW-1]}}, head.sy};
      sxy <= {{(TW-PW){head.sxy[PW-1]}}, head.sxy};
      sxx <= {{(TW-PW){head.sxx[PW-1]}}, head.sxx};
      syy <= {{(TW-PW){head.syy[PW-1]}}, head.syy};
    end
  end

endmodule
`default_nettype wire
